// File: rtl/fsfc_pkg.sv
// Shared types and constants of the flow sensor frame checker.
package fsfc_pkg;

  // Field widths.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned RAW_W  = 32;
  localparam int unsigned FLOW_W = 25;
  localparam int unsigned CFG_W  = 16;

  // Configuration register indexes.
  localparam logic REG_FLOW_OFFSET  = 1'b0;
  localparam logic REG_SCALE_FACTOR = 1'b1;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] FLOW_OFFSET_RST  = 16'd32000;
  localparam logic [CFG_W-1:0] SCALE_FACTOR_RST = 16'd140;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic crc_hi;
    logic crc_lo;
    logic update;
    logic div_step;
    logic finish;
  } fsfc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_serial;
    logic div_done;
    logic out_free;
  } fsfc_sts_t;

endpackage

// File: rtl/fsfc_in_if.sv
// Input request channel: one completed sensor read.
interface fsfc_in_if
  import fsfc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              is_serial;
  logic [BYTE_W-1:0] byte0;
  logic [BYTE_W-1:0] byte1;
  logic [BYTE_W-1:0] byte2;
  logic [BYTE_W-1:0] byte3;
  logic [BYTE_W-1:0] byte4;
  logic [BYTE_W-1:0] byte5;

  modport source (
    output valid, is_serial, byte0, byte1, byte2, byte3, byte4, byte5,
    input  ready
  );
  modport sink (
    input  valid, is_serial, byte0, byte1, byte2, byte3, byte4, byte5,
    output ready
  );
endinterface

// File: rtl/fsfc_out_if.sv
// Result request channel: held values and checksum flags of one read.
interface fsfc_out_if
  import fsfc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [FLOW_W-1:0] flow_fixed;
  logic        [RAW_W-1:0]  serial_number;
  logic        [RAW_W-1:0]  stored_value;
  logic                     first_crc_ok;
  logic                     second_crc_ok;

  modport source (
    output valid, flow_fixed, serial_number, stored_value, first_crc_ok, second_crc_ok,
    input  ready
  );
  modport sink (
    input  valid, flow_fixed, serial_number, stored_value, first_crc_ok, second_crc_ok,
    output ready
  );
endinterface

// File: rtl/flow_sensor_frame_checker.sv
// Flow sensor frame checker: CRC-8 checked sensor words, flow and serial number results.
// A flow read passes CRC_HI, CRC_LO, UPDATE, DIV and FINISH after acceptance, a serial read
// skips DIV; the restoring divider that turns the offset count into fixed point takes one
// quotient bit per cycle and sets the flow figure. FINISH waits while a result is held and
// not yet taken, and a new request is taken only once the block is back in IDLE.
// Reset: synchronous rst_n clears held values and the result valid flag and reloads the register defaults.
module flow_sensor_frame_checker
  import fsfc_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  fsfc_in_if.sink          in_ch,
  fsfc_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata
);

  fsfc_cmd_t cmd;
  fsfc_sts_t sts;

  // Sequencer.
  fsfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  fsfc_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .in_is_serial      (in_ch.is_serial),
    .in_byte0          (in_ch.byte0),
    .in_byte1          (in_ch.byte1),
    .in_byte2          (in_ch.byte2),
    .in_byte3          (in_ch.byte3),
    .in_byte4          (in_ch.byte4),
    .in_byte5          (in_ch.byte5),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_flow_fixed    (out_ch.flow_fixed),
    .out_serial_number (out_ch.serial_number),
    .out_stored_value  (out_ch.stored_value),
    .out_first_crc_ok  (out_ch.first_crc_ok),
    .out_second_crc_ok (out_ch.second_crc_ok)
  );

  // An accepted request keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input ready right after a request was accepted");

  // A matched second word only comes with a serial read, which copies the raw value.
  a_serial_copy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.second_crc_ok |-> out_ch.serial_number == out_ch.stored_value)
    else $error("serial number differs from raw value after a matched second word");

  // The result register is only loaded from the finishing step, never mid-divide.
  a_out_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> in_ch.ready)
    else $error("result appeared while a request was still in work");

endmodule

// File: rtl/fsfc_ctrl.sv
// Controller state machine that sequences checksum, update, divide and result.
module fsfc_ctrl
  import fsfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fsfc_sts_t sts,
  output fsfc_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC_HI,
    S_CRC_LO,
    S_UPDATE,
    S_DIV,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CRC_HI;
        end
      end
      S_CRC_HI: begin
        cmd.crc_hi = 1'b1;
        state_nxt  = S_CRC_LO;
      end
      S_CRC_LO: begin
        cmd.crc_lo = 1'b1;
        state_nxt  = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = sts.is_serial ? S_FINISH : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/fsfc_dp.sv
// Datapath: configuration, checksums, held state, restoring divider, result register.
module fsfc_dp
  import fsfc_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fsfc_cmd_t                cmd,
  output fsfc_sts_t                sts,
  input  logic                     cfg_we,
  input  logic                     cfg_idx,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_is_serial,
  input  logic [BYTE_W-1:0]        in_byte0,
  input  logic [BYTE_W-1:0]        in_byte1,
  input  logic [BYTE_W-1:0]        in_byte2,
  input  logic [BYTE_W-1:0]        in_byte3,
  input  logic [BYTE_W-1:0]        in_byte4,
  input  logic [BYTE_W-1:0]        in_byte5,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [FLOW_W-1:0] out_flow_fixed,
  output logic [RAW_W-1:0]         out_serial_number,
  output logic [RAW_W-1:0]         out_stored_value,
  output logic                     out_first_crc_ok,
  output logic                     out_second_crc_ok
);

  localparam int unsigned DVD_W = WORD_W + FRACTION_BITS;
  localparam int unsigned CNT_W = $clog2(DVD_W + 1);
  localparam logic [7:0]  CRC_POLY = 8'h31;
  localparam logic [32:0] FLOW_MAX = 33'h0FFFFFF;
  localparam logic [32:0] FLOW_MIN_MAG = 33'h1000000;

  // One byte through the CRC-8 register; the byte is already folded in.
  function automatic logic [7:0] crc8_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0] flow_offset_r;
  logic [CFG_W-1:0] scale_factor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow_offset_r  <= FLOW_OFFSET_RST;
      scale_factor_r <= SCALE_FACTOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FLOW_OFFSET:  flow_offset_r  <= cfg_wdata;
        REG_SCALE_FACTOR: scale_factor_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Captured request.
  logic              serial_r;
  logic [BYTE_W-1:0] b0_r, b1_r, b2_r, b3_r, b4_r, b5_r;
  logic [7:0]        crc1_r, crc2_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      serial_r <= in_is_serial;
      b0_r     <= in_byte0;
      b1_r     <= in_byte1;
      b2_r     <= in_byte2;
      b3_r     <= in_byte3;
      b4_r     <= in_byte4;
      b5_r     <= in_byte5;
    end
    if (cmd.crc_hi) begin
      crc1_r <= crc8_byte(b0_r);
      crc2_r <= crc8_byte(b3_r);
    end
    if (cmd.crc_lo) begin
      crc1_r <= crc8_byte(crc1_r ^ b1_r);
      crc2_r <= crc8_byte(crc2_r ^ b4_r);
    end
  end

  // Held state and the raw value after this read.
  logic [RAW_W-1:0]  raw_r, serial_held_r;
  logic [FLOW_W-1:0] flow_held_r;
  logic              ok1_r, ok2_r;
  logic              ok1, ok2;
  logic [RAW_W-1:0]  raw_first, raw_nxt;

  assign ok1       = (crc1_r == b2_r);
  assign ok2       = serial_r && (crc2_r == b5_r);
  assign raw_first = ok1 ? {16'd0, b0_r, b1_r} : raw_r;
  assign raw_nxt   = ok2 ? {raw_first[15:0], b3_r, b4_r} : raw_first;

  // Signed offset count and its magnitude.
  logic [WORD_W:0]   diff;
  logic [WORD_W:0]   diff_neg;
  logic [WORD_W-1:0] mag;

  assign diff     = {1'b0, raw_nxt[WORD_W-1:0]} - {1'b0, flow_offset_r};
  assign diff_neg = -diff;
  assign mag      = diff[WORD_W] ? diff_neg[WORD_W-1:0] : diff[WORD_W-1:0];

  // Restoring divider, one quotient bit per cycle; quotient shifts into dvd_r.
  logic [DVD_W-1:0]  dvd_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] div_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              neg_r;
  logic [WORD_W:0]   partial;
  logic [WORD_W+1:0] trial;

  assign partial = {rem_r, dvd_r[DVD_W-1]};
  assign trial   = {1'b0, partial} - {2'b00, div_r};

  always_ff @(posedge clk) begin
    if (cmd.update && !serial_r) begin
      dvd_r <= DVD_W'(mag) << FRACTION_BITS;
      rem_r <= '0;
      div_r <= (scale_factor_r == '0) ? WORD_W'(1) : scale_factor_r;
      cnt_r <= CNT_W'(DVD_W);
      neg_r <= diff[WORD_W];
    end else if (cmd.div_step) begin
      if (!trial[WORD_W+1]) begin
        rem_r <= trial[WORD_W-1:0];
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= partial[WORD_W-1:0];
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // Saturate the quotient and apply the sign.
  logic [32:0]       q_ext;
  logic [FLOW_W-1:0] q_sat;
  logic [FLOW_W-1:0] flow_new;
  logic [FLOW_W-1:0] flow_fin;

  assign q_ext = 33'(dvd_r);
  always_comb begin
    if (neg_r) begin
      q_sat = (q_ext > FLOW_MIN_MAG) ? FLOW_MIN_MAG[FLOW_W-1:0] : q_ext[FLOW_W-1:0];
    end else begin
      q_sat = (q_ext > FLOW_MAX) ? FLOW_MAX[FLOW_W-1:0] : q_ext[FLOW_W-1:0];
    end
  end
  assign flow_new = neg_r ? -q_sat : q_sat;
  assign flow_fin = serial_r ? flow_held_r : flow_new;

  // Held state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r         <= '0;
      flow_held_r   <= '0;
      serial_held_r <= '0;
    end else begin
      if (cmd.update) begin
        raw_r <= raw_nxt;
        ok1_r <= ok1;
        ok2_r <= ok2;
        if (serial_r) begin
          serial_held_r <= raw_nxt;
        end
      end
      if (cmd.finish) begin
        flow_held_r <= flow_fin;
      end
    end
  end

  // Result register.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_flow_fixed    <= flow_fin;
      out_serial_number <= serial_held_r;
      out_stored_value  <= raw_r;
      out_first_crc_ok  <= ok1_r;
      out_second_crc_ok <= ok2_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.is_serial = serial_r;
  assign sts.div_done  = (cnt_r == CNT_W'(1));
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

// File: bench/tb.sv
// Self-checking testbench of the flow sensor frame checker: directed and random sensor reads.
`timescale 1ns / 1ps

module tb;
  import fsfc_pkg::*;

  localparam int unsigned FRAC_BITS      = 8;
  localparam logic [7:0]  CRC_POLY       = 8'h31;
  localparam logic [63:0] FLOW_MAX_MAG   = 64'h0FF_FFFF;
  localparam logic [63:0] FLOW_MIN_MAG   = 64'h100_0000;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          PHASE_READS    = 200;
  localparam int          REPORT_LIMIT   = 10;

  // One completed sensor read as it goes over the input channel.
  typedef struct packed {
    logic              is_serial;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] byte2;
    logic [BYTE_W-1:0] byte3;
    logic [BYTE_W-1:0] byte4;
    logic [BYTE_W-1:0] byte5;
  } sensor_read_t;

  // Held values and checksum flags that one read leaves behind.
  typedef struct packed {
    logic signed [FLOW_W-1:0] flow_fixed;
    logic        [RAW_W-1:0]  serial_number;
    logic        [RAW_W-1:0]  stored_value;
    logic                     first_crc_ok;
    logic                     second_crc_ok;
  } read_outcome_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  fsfc_in_if  in_bus ();
  fsfc_out_if out_bus ();

  flow_sensor_frame_checker #(
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // Mirror of the block's registers and held values.
  logic        [CFG_W-1:0]  offset_q;
  logic        [CFG_W-1:0]  scale_q;
  logic        [RAW_W-1:0]  raw_q;
  logic signed [FLOW_W-1:0] flow_q;
  logic        [RAW_W-1:0]  serial_q;

  read_outcome_t pending_outcomes[$];

  int  fail_count;
  int  read_count;
  int  serial_count;
  int  crc_fail_count;
  int  setting_count;
  int  idle_cycles;
  int  stall_left;
  bit  steady;

  // Clock with a 12 ns period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // CRC-8 over one 16-bit word, MSB first, no reflection, zero start.
  function automatic logic [7:0] crc8_word(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0]  crc;
    logic [15:0] word;
    crc  = 8'h00;
    word = {hi, lo};
    for (int i = 15; i >= 0; i--) begin
      crc = (crc[7] ^ word[i]) ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
    end
    return crc;
  endfunction

  // Offset count divided by the scale factor, in fixed point, truncated toward zero.
  function automatic logic [FLOW_W-1:0] count_to_fixed(input logic [WORD_W-1:0] count,
                                                       input logic [CFG_W-1:0]  offset,
                                                       input logic [CFG_W-1:0]  scale);
    logic              neg;
    logic [WORD_W-1:0] mag;
    logic [63:0]       divisor;
    logic [63:0]       quo;
    neg     = count < offset;
    mag     = neg ? offset - count : count - offset;
    divisor = (scale == '0) ? 64'd1 : 64'(scale);
    quo     = (64'(mag) << FRAC_BITS) / divisor;
    if (neg) begin
      if (quo > FLOW_MIN_MAG) quo = FLOW_MIN_MAG;
      return FLOW_W'(64'd0 - quo);
    end
    if (quo > FLOW_MAX_MAG) quo = FLOW_MAX_MAG;
    return FLOW_W'(quo);
  endfunction

  // Update the mirrored state with one read and return what the block should show.
  function automatic read_outcome_t predict_outcome(input sensor_read_t rd);
    read_outcome_t res;
    logic          ok1;
    logic          ok2;
    ok1 = crc8_word(rd.byte0, rd.byte1) == rd.byte2;
    ok2 = 1'b0;
    if (ok1) raw_q = {16'h0000, rd.byte0, rd.byte1};
    if (rd.is_serial) begin
      ok2 = crc8_word(rd.byte3, rd.byte4) == rd.byte5;
      if (ok2) raw_q = {raw_q[15:0], rd.byte3, rd.byte4};
      serial_q = raw_q;
    end else begin
      flow_q = count_to_fixed(raw_q[15:0], offset_q, scale_q);
    end
    res.flow_fixed    = flow_q;
    res.serial_number = serial_q;
    res.stored_value  = raw_q;
    res.first_crc_ok  = ok1;
    res.second_crc_ok = ok2;
    return res;
  endfunction

  // Checksum byte for a word: the right one, or one that is sure to be wrong.
  function automatic logic [7:0] crc_byte(input logic [15:0] word, input bit good);
    logic [7:0] crc;
    crc = crc8_word(word[15:8], word[7:0]);
    return good ? crc : crc ^ 8'($urandom_range(1, 255));
  endfunction

  function automatic sensor_read_t flow_read(input logic [15:0] word, input bit good);
    sensor_read_t rd;
    rd.is_serial = 1'b0;
    {rd.byte0, rd.byte1} = word;
    rd.byte2 = crc_byte(word, good);
    {rd.byte3, rd.byte4, rd.byte5} = 24'($urandom);
    return rd;
  endfunction

  function automatic sensor_read_t serial_read(input logic [15:0] hi_word, input bit good1,
                                               input logic [15:0] lo_word, input bit good2);
    sensor_read_t rd;
    rd.is_serial = 1'b1;
    {rd.byte0, rd.byte1} = hi_word;
    rd.byte2 = crc_byte(hi_word, good1);
    {rd.byte3, rd.byte4} = lo_word;
    rd.byte5 = crc_byte(lo_word, good2);
    return rd;
  endfunction

  task automatic flag_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) flag_failure($sformatf("%s expected %0h, got %0h", name, want, got));
  endtask

  // Send one read, then predict its outcome once the request is accepted.
  task automatic send_read(input sensor_read_t rd);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.is_serial <= rd.is_serial;
    in_bus.byte0     <= rd.byte0;
    in_bus.byte1     <= rd.byte1;
    in_bus.byte2     <= rd.byte2;
    in_bus.byte3     <= rd.byte3;
    in_bus.byte4     <= rd.byte4;
    in_bus.byte5     <= rd.byte5;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pending_outcomes.push_back(predict_outcome(rd));
    read_count++;
    if (rd.is_serial) serial_count++;
    if (crc8_word(rd.byte0, rd.byte1) != rd.byte2) crc_fail_count++;
  endtask

  // Stop sending and let every pending outcome come back.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FLOW_OFFSET) offset_q = value;
    else scale_q = value;
    @(posedge clk);
  endtask

  task automatic set_registers(input logic [CFG_W-1:0] offset, input logic [CFG_W-1:0] scale);
    wait_drained();
    write_reg(REG_FLOW_OFFSET, offset);
    write_reg(REG_SCALE_FACTOR, scale);
    setting_count++;
  endtask

  // Flow reads at the register defaults, with bad checksums reconverting the old value.
  task automatic test_default_flow();
    send_read(flow_read(16'h1234, 1'b0));
    send_read(flow_read(16'd32000, 1'b1));
    send_read(flow_read(16'h0000, 1'b1));
    send_read(flow_read(16'hFFFF, 1'b1));
    send_read(flow_read(16'h0000, 1'b0));
    send_read(flow_read(16'd32140, 1'b1));
  endtask

  // Serial reads with every pairing of good and bad checksums.
  task automatic test_serial_reads();
    send_read(serial_read(16'h1234, 1'b1, 16'h5678, 1'b1));
    send_read(serial_read(16'hABCD, 1'b1, 16'h0000, 1'b0));
    send_read(serial_read(16'h0000, 1'b0, 16'hBEEF, 1'b1));
    send_read(serial_read(16'h0F0F, 1'b0, 16'hF0F0, 1'b0));
    send_read(serial_read(16'hFFFF, 1'b1, 16'hFFFF, 1'b1));
    // A flow read after serial ones converts the low half of the stored value.
    send_read(flow_read(16'h0000, 1'b0));
  endtask

  // Register extremes, including a zero scale factor.
  task automatic test_register_extremes();
    set_registers(16'h0000, 16'h0001);
    send_read(flow_read(16'hFFFF, 1'b1));
    send_read(flow_read(16'h0000, 1'b1));
    set_registers(16'hFFFF, 16'h0001);
    send_read(flow_read(16'h0000, 1'b1));
    set_registers(16'h0000, 16'h0000);
    send_read(flow_read(16'hFFFF, 1'b1));
    set_registers(16'hFFFF, 16'hFFFF);
    send_read(flow_read(16'h0000, 1'b1));
    set_registers(16'h0000, 16'hFFFF);
    send_read(flow_read(16'hFFFF, 1'b1));
  endtask

  // Random reads over several register settings: mostly well formed, some pure noise.
  task automatic test_random_phases();
    sensor_read_t rd;
    logic [15:0]  word;
    for (int phase = 0; phase < 5; phase++) begin
      unique case (phase)
        0: set_registers(FLOW_OFFSET_RST, SCALE_FACTOR_RST);
        1: set_registers(16'($urandom), 16'($urandom_range(1, 65535)));
        2: set_registers(16'($urandom), 16'($urandom_range(1, 300)));
        3: set_registers($urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom_range(1, 4)));
        default: set_registers(16'($urandom), 16'($urandom_range(1, 2000)));
      endcase
      for (int n = 0; n < PHASE_READS; n++) begin
        steady = (phase == 4) || (n >= 50 && n < 80);
        // Once, in phase 2, the sender holds off until everything has come back.
        if (phase == 2 && n == 100) wait_drained();
        if ($urandom_range(0, 99) < 15) begin
          rd = sensor_read_t'({$urandom, $urandom});
        end else begin
          if ($urandom_range(0, 99) < 30) word = offset_q + 16'($signed($urandom_range(0, 1000)) - 500);
          else word = 16'($urandom);
          if ($urandom_range(0, 99) < 40) begin
            rd = serial_read(word, $urandom_range(0, 99) < 85,
                             16'($urandom), $urandom_range(0, 99) < 85);
          end else begin
            rd = flow_read(word, $urandom_range(0, 99) < 85);
          end
        end
        send_read(rd);
      end
      steady = 1'b0;
    end
  endtask

  // Result side: random stalls; no new stall starts during steady stretches.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 4) == 0) begin
      stall_left    <= pick_gap();
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Compare every delivered result with the oldest prediction.
  always @(posedge clk) begin
    read_outcome_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_outcomes.size() == 0) begin
        flag_failure("result delivered with no read pending");
      end else begin
        want = pending_outcomes.pop_front();
        check_field("flow_fixed", 32'(want.flow_fixed), 32'(out_bus.flow_fixed));
        check_field("serial_number", want.serial_number, out_bus.serial_number);
        check_field("stored_value", want.stored_value, out_bus.stored_value);
        check_field("first_crc_ok", 32'(want.first_crc_ok), 32'(out_bus.first_crc_ok));
        check_field("second_crc_ok", 32'(want.second_crc_ok), 32'(out_bus.second_crc_ok));
      end
    end
  end

  // Count cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_FLOW_OFFSET;
    cfg_wdata        = '0;
    in_bus.valid     = 1'b0;
    in_bus.is_serial = 1'b0;
    in_bus.byte0     = '0;
    in_bus.byte1     = '0;
    in_bus.byte2     = '0;
    in_bus.byte3     = '0;
    in_bus.byte4     = '0;
    in_bus.byte5     = '0;
    out_bus.ready    = 1'b0;
    stall_left       = 0;
    steady           = 1'b0;
    fail_count       = 0;
    read_count       = 0;
    serial_count     = 0;
    crc_fail_count   = 0;
    setting_count    = 1;
    offset_q         = FLOW_OFFSET_RST;
    scale_q          = SCALE_FACTOR_RST;
    raw_q            = '0;
    flow_q           = '0;
    serial_q         = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_flow();
    test_serial_reads();
    test_register_extremes();
    test_random_phases();

    wait_drained();
    repeat (40) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      flag_failure($sformatf("%0d predicted results never arrived", pending_outcomes.size()));
    end

    $display("Run covered %0d sensor reads (%0d serial, %0d with a bad first checksum)",
             read_count, serial_count, crc_fail_count);
    $display("over %0d register settings, with random gaps and stalls on both channels.",
             setting_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: flow_sensor_frame_checker.f
rtl/fsfc_pkg.sv
rtl/fsfc_in_if.sv
rtl/fsfc_out_if.sv
rtl/fsfc_ctrl.sv
rtl/fsfc_dp.sv
rtl/flow_sensor_frame_checker.sv
bench/tb.sv
